FILE: rtl/core/mtvs_pkg.sv
// mtvs_pkg: constants, types and word functions of the mt19937 victim selector
// no dependencies; used by the channel interfaces, the cells, the remainder unit and the top level

package mtvs_pkg;

    localparam int          MT_N        = 624;
    localparam int          MT_M        = 397;
    localparam int          WORD_W      = 32;
    localparam int          FRAME_W     = 5;
    localparam int          POS_W       = 10;
    localparam logic [31:0] MT_INIT_MUL = 32'h6c07_8965;
    localparam logic [31:0] MT_MATRIX   = 32'h9908_b0df;
    localparam logic [31:0] MT_TEMPER_B = 32'h9d2c_5680;
    localparam logic [31:0] MT_TEMPER_C = 32'hefc6_0000;
    localparam logic [31:0] SEED_RESET  = 32'd5489;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [FRAME_W-1:0] frame_t;
    typedef logic [POS_W-1:0]   pos_t;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_READY,
        ST_CALC
    } mtvs_state_t;

    // remainder unit status, seen by the top level
    typedef struct packed {
        logic   done;
        frame_t frame;
    } mod_status_t;

    // seeding recurrence, one word from the previous one
    function automatic word_t seed_step(input word_t prev, input pos_t idx);
        word_t x;
        x = prev ^ (prev >> 30);
        return (x * MT_INIT_MUL) + {{(WORD_W-POS_W){1'b0}}, idx};
    endfunction

    // one word of the twist from words k, k+1 and k+397
    function automatic word_t twist_word(input word_t w0, input word_t w1, input word_t wm);
        word_t mix;
        word_t y;
        mix = {w0[31], w1[30:0]};
        y   = wm ^ {1'b0, mix[31:1]};
        if (mix[0])
        begin
            y = y ^ MT_MATRIX;
        end
        return y;
    endfunction

    function automatic word_t temper(input word_t w);
        word_t y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & MT_TEMPER_B);
        y = y ^ ((y << 15) & MT_TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

FILE: rtl/core/mtvs_if.sv
// mtvs_if: valid/ready channels of the victim selector (seed, draw request, result)
// depends on mtvs_pkg

interface mtvs_seed_if
    import mtvs_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t seed;

    modport source (output valid, output seed, input ready);
    modport sink   (input valid, input seed, output ready);
endinterface

interface mtvs_draw_if
    import mtvs_pkg::*;
();
    logic valid;
    logic ready;
    logic draw_request;

    modport source (output valid, output draw_request, input ready);
    modport sink   (input valid, input draw_request, output ready);
endinterface

interface mtvs_result_if
    import mtvs_pkg::*;
();
    logic   valid;
    logic   ready;
    frame_t victim_frame;
    word_t  random_word;

    modport source (output valid, output victim_frame, output random_word, input ready);
    modport sink   (input valid, input victim_frame, input random_word, output ready);
endinterface

FILE: rtl/core/mtvs_cell.sv
// mtvs_cell: one state word of the generator shift chain
// depends on mtvs_pkg

module mtvs_cell
    import mtvs_pkg::*;
(
    input  logic  clk,
    input  logic  shift_en,
    input  word_t word_in,
    output word_t word_out
);

    word_t word_reg;
    word_t word_next;

    always_comb
    begin
        word_next = shift_en ? word_in : word_reg;
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word_out = word_reg;

endmodule

FILE: rtl/core/mtvs_mod_unit.sv
// mtvs_mod_unit: tempered word modulo the frame count by reciprocal multiply
// depends on mtvs_pkg; a power-of-two frame count is taken as a registered mask instead

module mtvs_mod_unit
    import mtvs_pkg::*;
#(
    parameter int DIVISOR = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  word_t       word_in,
    output mod_status_t status
);

    localparam bit IS_POW2 = (DIVISOR & (DIVISOR - 1)) == 0;

    logic   done_reg;
    logic   done_next;
    frame_t frame_out;

    generate
        if (IS_POW2)
        begin : g_mask
            localparam word_t MASK = WORD_W'(DIVISOR - 1);

            frame_t frame_reg;

            always_comb
            begin
                done_next = start ? 1'b1 : done_reg;
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    frame_reg <= FRAME_W'(word_in & MASK);
                end
            end

            assign frame_out = frame_reg;
        end
        else
        begin : g_recip
            // rounded-up reciprocal: quotient is a multiply-high plus a halved fix-up term
            localparam int          L       = $clog2(DIVISOR);
            localparam logic [63:0] M_WIDE  = (((64'd1 << 32) * ((64'd1 << L) - 64'(DIVISOR)))
                                               / 64'(DIVISOR)) + 64'd1;
            localparam word_t       M_CONST = M_WIDE[WORD_W-1:0];
            localparam word_t       DIV_W   = WORD_W'(DIVISOR);

            logic [3:0]          step_reg;
            logic [3:0]          step_next;
            word_t               n_reg;
            word_t               n_next;
            word_t               t_reg;
            word_t               t_next;
            word_t               q_reg;
            word_t               q_next;
            word_t               qd_reg;
            word_t               qd_next;
            word_t               rem_reg;
            word_t               rem_next;
            logic [2*WORD_W-1:0] prod;

            always_comb
            begin
                prod      = {{WORD_W{1'b0}}, M_CONST} * {{WORD_W{1'b0}}, n_reg};
                n_next    = start ? word_in : n_reg;
                step_next = start ? 4'b0001 : {step_reg[2:0], 1'b0};
                // multiply-high, fix-up, back-multiply, subtract: one step per cycle
                t_next    = prod[2*WORD_W-1:WORD_W];
                q_next    = (t_reg + ((n_reg - t_reg) >> 1)) >> (L - 1);
                qd_next   = q_reg * DIV_W;
                rem_next  = n_reg - qd_reg;
                if (start)
                begin
                    done_next = 1'b0;
                end
                else if (step_reg[3])
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    done_next = done_reg;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    step_reg <= '0;
                end
                else
                begin
                    step_reg <= step_next;
                end
            end

            always_ff @(posedge clk)
            begin
                n_reg   <= n_next;
                t_reg   <= t_next;
                q_reg   <= q_next;
                qd_reg  <= qd_next;
                rem_reg <= rem_next;
            end

            assign frame_out = FRAME_W'(rem_reg);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    assign status.done  = done_reg;
    assign status.frame = frame_out;

endmodule

FILE: rtl/core/mt19937_random_victim_select.sv
// mt19937_random_victim_select: victim frame picker on an mt19937 generator
// result: the frame is a mask of the tempered word when NUM_FRAMES is a power of two, else a
// four-step reciprocal remainder; a new draw is taken only once the last result is loaded
// reset: seed goes to 5489 and the 624-word shift chain refills, one word per cycle;
// a seed write starts the same refill; draw ready is low meanwhile
// depends on mtvs_pkg, mtvs_if, mtvs_cell, mtvs_mod_unit

module mt19937_random_victim_select
    import mtvs_pkg::*;
#(
    parameter int NUM_FRAMES = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    mtvs_seed_if.sink            cfg,
    mtvs_draw_if.sink            draw,
    mtvs_result_if.source        result
);

    localparam pos_t LAST_POS = POS_W'(MT_N - 1);

    // control state
    mtvs_state_t state_reg;
    mtvs_state_t state_next;
    pos_t        fill_cnt_reg;
    pos_t        fill_cnt_next;
    word_t       seed_reg;
    word_t       seed_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    // result payload
    word_t       word_reg;
    word_t       word_next;
    frame_t      frame_reg;
    frame_t      frame_next;

    // shift chain: cell 0 holds the oldest word, new words enter at the tail
    word_t       chain_word [MT_N];
    word_t       tail_in;
    logic        shift_en;

    logic        draw_take;
    logic        out_load;
    word_t       new_word;
    word_t       tempered;
    mod_status_t mod_status;

    genvar gi;
    generate
        for (gi = 0; gi < MT_N; gi++)
        begin : g_cell
            if (gi == MT_N - 1)
            begin : g_tail
                mtvs_cell u_cell (
                    .clk      (clk),
                    .shift_en (shift_en),
                    .word_in  (tail_in),
                    .word_out (chain_word[gi])
                );
            end
            else
            begin : g_body
                mtvs_cell u_cell (
                    .clk      (clk),
                    .shift_en (shift_en),
                    .word_in  (chain_word[gi+1]),
                    .word_out (chain_word[gi])
                );
            end
        end
    endgenerate

    // next generator word from positions k, k+1, k+397 of the chain
    assign new_word = twist_word(chain_word[0], chain_word[1], chain_word[MT_M]);
    assign tempered = temper(new_word);

    mtvs_mod_unit #(
        .DIVISOR (NUM_FRAMES)
    ) u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (draw_take),
        .word_in (tempered),
        .status  (mod_status)
    );

    assign cfg.ready  = 1'b1;
    assign draw.ready = (state_reg == ST_READY);

    // a request bit of zero is taken but leaves the generator alone
    assign draw_take = draw.valid && draw.ready && draw.draw_request;

    always_comb
    begin
        state_next     = state_reg;
        fill_cnt_next  = fill_cnt_reg;
        seed_next      = seed_reg;
        out_valid_next = out_valid_reg;
        word_next      = word_reg;
        frame_next     = frame_reg;
        shift_en       = 1'b0;
        tail_in        = new_word;
        out_load       = 1'b0;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_FILL:
            begin
                // first word is the seed, then the init recurrence off the tail
                shift_en = 1'b1;
                if (fill_cnt_reg == '0)
                begin
                    tail_in = seed_reg;
                end
                else
                begin
                    tail_in = seed_step(chain_word[MT_N-1], fill_cnt_reg);
                end
                fill_cnt_next = fill_cnt_reg + 1'b1;
                if (fill_cnt_reg == LAST_POS)
                begin
                    state_next = ST_READY;
                end
            end
            ST_READY:
            begin
                if (draw_take)
                begin
                    shift_en   = 1'b1;
                    word_next  = tempered;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                // wait for the remainder and a free output slot
                if (mod_status.done && (!out_valid_reg || result.ready))
                begin
                    out_load   = 1'b1;
                    state_next = ST_READY;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
            frame_next     = mod_status.frame;
        end

        // a seed write restarts the fill from the new seed
        if (cfg.valid && cfg.ready)
        begin
            seed_next     = cfg.seed;
            fill_cnt_next = '0;
            state_next    = ST_FILL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            fill_cnt_reg  <= '0;
            seed_reg      <= SEED_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_cnt_reg  <= fill_cnt_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // the word register holds the draw's word until it is handed to the output
    word_t out_word_reg;
    word_t out_word_next;

    always_comb
    begin
        out_word_next = out_load ? word_reg : out_word_reg;
    end

    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        frame_reg    <= frame_next;
        out_word_reg <= out_word_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.victim_frame = frame_reg;
    assign result.random_word  = out_word_reg;

endmodule
